// File: rtl/smoothed_temperature_sensor_defines.svh
// Assertion macros used by the smoothed temperature sensor checker.
`ifndef SMOOTHED_TEMPERATURE_SENSOR_DEFINES_SVH
`define SMOOTHED_TEMPERATURE_SENSOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define STS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sts_pkg.sv
// Shared constants and types of the smoothed temperature sensor.
package sts_pkg;

  localparam int WINDOW_DEF  = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int SAMPLE_W = 10;
  localparam int AREF_W   = 11;
  localparam int RAW_W    = 10;
  localparam int CENTI_W  = 14;
  localparam int DECI_W   = 12;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_PAD_W   = 4;
  localparam int OUT_TDATA_W = RAW_W + CENTI_W + DECI_W + OUT_PAD_W;

  localparam logic [AREF_W-1:0] AREF_RESET = 11'd1076;
  localparam int FULL_SCALE = 1023;
  localparam int AREF_FULL  = 2047;

  localparam logic [CENTI_W-1:0] CENTI_MAX   = 14'h3FFF;
  localparam logic [DECI_W-1:0]  DECI_OFFSET = 12'd320;
  // Fahrenheit scale 18/100 reduced to 9/50.
  localparam int DECI_MUL = 9;
  localparam int DECI_DIV = 50;

  typedef struct packed {
    logic [RAW_W-1:0]   raw_average;
    logic [CENTI_W-1:0] temp_centi_celsius;
    logic [DECI_W-1:0]  temp_deci_fahrenheit;
    logic               too_hot;
  } sts_result_t;

endpackage

// File: rtl/sts_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
module sts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sts_front.sv
// Front end: accept samples, keep the sample ring and the running total.
module sts_front #(
  parameter int WINDOW = sts_pkg::WINDOW_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_valid,
  output logic                                     s_ready,
  input  logic [sts_pkg::SAMPLE_W-1:0]             s_sample,
  input  logic [$clog2(sts_pkg::QUEUE_DEPTH+1)-1:0] q_level,
  output logic                                     push,
  output logic [$clog2(sts_pkg::FULL_SCALE*WINDOW+1)-1:0] push_total
);
  import sts_pkg::*;

  localparam int POS_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int TOT_W  = $clog2(FULL_SCALE * WINDOW + 1);
  localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_DONE = FILL_W'(WINDOW);

  logic [POS_W-1:0]    wr_pos;
  logic [FILL_W-1:0]   fill_count;
  logic                s1_valid;
  logic                s1_full;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [SAMPLE_W-1:0] old_sample;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    total_next;
  logic [LVL_W-1:0]    in_flight;
  logic                accept;

  // Reserve a queue slot for the request still in the total stage.
  assign in_flight = q_level + LVL_W'(s1_valid);
  assign s_ready   = in_flight < LVL_W'(QUEUE_DEPTH);
  assign accept    = s_valid && s_ready;

  // Read the oldest sample and overwrite it in the same cycle.
  sts_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (accept),
    .waddr(wr_pos),
    .wdata(s_sample),
    .raddr(wr_pos),
    .rdata(old_sample)
  );

  assign total_next = total - (s1_full ? TOT_W'(old_sample) : '0) + TOT_W'(s1_sample);

  // Only requests past the fill phase produce a result.
  assign push       = s1_valid && s1_full;
  assign push_total = total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos     <= '0;
      fill_count <= '0;
      s1_valid   <= 1'b0;
      total      <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        wr_pos <= (wr_pos == POS_LAST) ? '0 : wr_pos + POS_W'(1);
        if (fill_count != FILL_DONE) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end
      if (s1_valid) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= s_sample;
      s1_full   <= (fill_count == FILL_DONE);
    end
  end

endmodule

// File: rtl/sts_queue.sv
// Short FIFO of running totals between the front and back ends.
module sts_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = sts_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic                       pop_valid,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import sts_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign pop_valid = (level != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + LVL_W'(1);
      end else if (pop && !push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/sts_back.sv
// Back end: scale the running total into average, Celsius and Fahrenheit.
module sts_back #(
  parameter int WINDOW = sts_pkg::WINDOW_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic [sts_pkg::AREF_W-1:0]                     aref,
  input  logic                                           q_valid,
  input  logic [$clog2(sts_pkg::FULL_SCALE*WINDOW+1)-1:0] q_total,
  output logic                                           q_pop,
  output logic                                           m_valid,
  input  logic                                           m_ready,
  output sts_pkg::sts_result_t                           result
);
  import sts_pkg::*;

  localparam int TOT_W = $clog2(FULL_SCALE * WINDOW + 1);
  localparam int PC_W  = TOT_W + AREF_W;

  // Exact division by a constant: floor(x * ceil(2^S / D) / 2^S).
  localparam int DIV_C = 100 * WINDOW;
  localparam int SH_C  = PC_W + $clog2(DIV_C);
  localparam int PCC_W = 2 * PC_W + 1;
  localparam logic [63:0] MUL_C = ((64'd1 << SH_C) + 64'(DIV_C) - 64'd1) / 64'(DIV_C);

  localparam int SH_R = TOT_W + $clog2(WINDOW);
  localparam int PR_W = 2 * TOT_W + 1;
  localparam logic [63:0] MUL_R = ((64'd1 << SH_R) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  localparam int CEN_MAXV = (FULL_SCALE * WINDOW * AREF_FULL) / (100 * WINDOW);
  localparam int CEN_W    = $clog2(CEN_MAXV + 1);
  localparam int X_W      = $clog2(CEN_MAXV * DECI_MUL + 1);
  localparam int SH_F     = X_W + $clog2(DECI_DIV);
  localparam int PF_W     = 2 * X_W + 1;
  localparam logic [63:0] MUL_F =
    ((64'd1 << SH_F) + 64'(DECI_DIV) - 64'd1) / 64'(DECI_DIV);

  logic advance;
  logic v1, v2, v3, v4;

  logic [PC_W-1:0]    p1_prod_c;
  logic [PR_W-1:0]    p1_prod_r;
  logic               p1_hot;
  logic [PCC_W-1:0]   prod_c2;
  logic [CEN_W-1:0]   p2_centi;
  logic [RAW_W-1:0]   p2_raw;
  logic               p2_hot;
  logic [X_W-1:0]     p3_x9;
  logic [CENTI_W-1:0] p3_centi;
  logic [RAW_W-1:0]   p3_raw;
  logic               p3_hot;
  logic [PF_W-1:0]    p4_prod_f;
  logic [CENTI_W-1:0] p4_centi;
  logic [RAW_W-1:0]   p4_raw;
  logic               p4_hot;

  // The whole pipe moves when the output register is free or being taken.
  assign advance = !m_valid || m_ready;
  assign q_pop   = advance && q_valid;
  assign prod_c2 = PCC_W'(p1_prod_c) * PCC_W'(MUL_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      m_valid <= 1'b0;
    end else if (advance) begin
      v1      <= q_valid;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      m_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_prod_c <= PC_W'(q_total) * PC_W'(aref);
      p1_prod_r <= PR_W'(q_total) * PR_W'(MUL_R);
      p1_hot    <= (q_total == TOT_W'(FULL_SCALE * WINDOW));

      p2_centi <= prod_c2[SH_C +: CEN_W];
      p2_raw   <= p1_prod_r[SH_R +: RAW_W];
      p2_hot   <= p1_hot;

      p3_x9    <= X_W'(p2_centi) * X_W'(DECI_MUL);
      p3_centi <= (p2_centi > CEN_W'(CENTI_MAX)) ? CENTI_MAX : p2_centi[CENTI_W-1:0];
      p3_raw   <= p2_raw;
      p3_hot   <= p2_hot;

      p4_prod_f <= PF_W'(p3_x9) * PF_W'(MUL_F);
      p4_centi  <= p3_centi;
      p4_raw    <= p3_raw;
      p4_hot    <= p3_hot;

      result.raw_average          <= p4_raw;
      result.temp_centi_celsius   <= p4_centi;
      result.temp_deci_fahrenheit <= p4_prod_f[SH_F +: DECI_W] + DECI_OFFSET;
      result.too_hot              <= p4_hot;
    end
  end

endmodule

// File: rtl/smoothed_temperature_sensor.sv
// A result passes the total stage, the queue, stages p1-p4 and the output register.
// Throughput: one sample per cycle while m_tready stays high; the front end
// holds s_tready low only when its 4-entry total queue could overflow.
// The first WINDOW samples after reset fill the ring and return no result.
// Reset (rst, synchronous): clears the pipe, queue, ring position, total and
// fill count, and loads aref_millivolts with 1076; the ring needs no clearing.
module smoothed_temperature_sensor #(
  parameter int WINDOW = sts_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: aref_millivolts.
  input  logic                              cfg_wr_en,
  input  logic [sts_pkg::AREF_W-1:0]        cfg_wr_data,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sts_pkg::IN_TDATA_W-1:0]    s_tdata,   // [9:0] sample, [15:10] zero
  // Output stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sts_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [9:0] raw_average,
                                                       // [23:10] temp_centi_celsius,
                                                       // [35:24] temp_deci_fahrenheit,
                                                       // [39:36] zero
  output logic                              m_tuser    // [0] too_hot
);
  import sts_pkg::*;

  localparam int TOT_W = $clog2(FULL_SCALE * WINDOW + 1);
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic [AREF_W-1:0] aref;
  logic              push;
  logic [TOT_W-1:0]  push_total;
  logic              q_valid;
  logic [TOT_W-1:0]  q_total;
  logic              q_pop;
  logic [LVL_W-1:0]  q_level;
  sts_result_t       result;

  // Reference voltage register; the user must write it only while the block
  // is idle so in-flight requests never see a change; this is not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      aref <= AREF_RESET;
    end else if (cfg_wr_en) begin
      aref <= cfg_wr_data;
    end
  end

  // Front end: ring and total update, one request per cycle while queue has room.
  sts_front #(
    .WINDOW(WINDOW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_sample  (s_tdata[SAMPLE_W-1:0]),
    .q_level   (q_level),
    .push      (push),
    .push_total(push_total)
  );

  // Decouple the total update from the scaling pipe so each can stall alone.
  sts_queue #(
    .WIDTH(TOT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_total),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_total),
    .level    (q_level)
  );

  // Back end: constant-reciprocal scaling, then the output register.
  sts_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .aref   (aref),
    .q_valid(q_valid),
    .q_total(q_total),
    .q_pop  (q_pop),
    .m_valid(m_tvalid),
    .m_ready(m_tready),
    .result (result)
  );

  // Pack the result fields, lowest field first, padded to whole bytes.
  assign m_tdata = {{OUT_PAD_W{1'b0}}, result.temp_deci_fahrenheit,
                    result.temp_centi_celsius, result.raw_average};
  assign m_tuser = result.too_hot;

endmodule

// File: rtl/sts_checker.sv
// Port-level checks of the smoothed temperature sensor, bound to the top level.
`include "smoothed_temperature_sensor_defines.svh"

module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  // A too-hot window averages to full scale.
  `STS_ASSERT_IMPL(a_hot_full_scale, m_tvalid && m_tuser, m_tdata[9:0] == 10'd1023, "too_hot without full-scale average")

  // A zero average means a total below the window, so Celsius stays tiny.
  `STS_ASSERT_IMPL(a_zero_avg_cold, m_tvalid && (m_tdata[9:0] == 10'd0), m_tdata[23:10] < 14'd21, "zero average with large Celsius value")

  // Fahrenheit never drops below its freezing offset.
  `STS_ASSERT_IMPL(a_deci_offset, m_tvalid, m_tdata[35:24] >= 12'd320, "Fahrenheit below offset")

  // A stalled result holds.
  `STS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

endmodule

bind smoothed_temperature_sensor sts_checker u_sts_checker (.*);

// File: tb/tb_smoothed_temperature_sensor.sv
`timescale 1ns / 1ps
// Self-checking stream testbench of the moving-average temperature sensor.
module tb_smoothed_temperature_sensor;
  import sts_pkg::*;

  localparam int WIN          = WINDOW_DEF;
  localparam int POS_W        = $clog2(WIN);
  localparam int GAP_MAX      = 17;
  // Settle margin past the output pipeline before touching the register.
  localparam int SETTLE       = 12;
  localparam int HOLD_LEN     = 400;
  localparam int HOLD_EVERY   = 300;
  localparam int HOLD_TIMES   = 2;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  localparam int AREF_LOW  = 1000;
  localparam int AREF_HIGH = 1200;

  // Fahrenheit conversion: tenths of F = centi-C * 18 / 100 + 320.
  localparam int F_MUL    = 18;
  localparam int F_DIV    = 100;
  localparam int F_OFFSET = 320;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [AREF_W-1:0]      cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [9:0] sample, [15:10] zero
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // [9:0] raw, [23:10] centi-C, [35:24] deci-F
  logic                   m_tuser;         // [0] too_hot

  // Samples waiting to be offered, and readings waiting to come out.
  logic [SAMPLE_W-1:0] pending_samples[$];
  sts_result_t         expected_readings[$];

  // Private copy of the filter state and the reference setting.
  logic [SAMPLE_W-1:0] ring_copy [WIN];
  logic [POS_W-1:0]    next_slot      = '0;
  int unsigned         window_sum     = 0;
  int unsigned         samples_filled = 0;
  int unsigned         aref_copy      = 32'(AREF_RESET);

  int queued_count   = 0;
  int accepted_count = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int random_count   = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  int holds_done     = 0;

  // Idle pattern state of each side: cycles still to wait, items left in the
  // current stretch, and whether the stretch runs without gaps.
  int src_wait  = 0;
  int src_left  = 0;
  bit src_calm  = 1'b0;
  int sink_wait = 0;
  int sink_left = 0;
  bit sink_calm = 1'b0;

  int          phase_len;
  int          pick;
  int          k;
  logic [AREF_W-1:0] aref_pick;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  smoothed_temperature_sensor #(
    .WINDOW(WIN)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  // Draw the wait before the next request. Stretches of random length
  // alternate between no gaps at all and random gaps of up to GAP_MAX.
  function automatic int draw_gap(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(20, 160);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Advance the filter copy by one sample; queue a reading once the ring is full.
  function automatic void predict_reading(input logic [SAMPLE_W-1:0] smp);
    sts_result_t r;
    int unsigned centi;
    int unsigned deci;
    // Drop the oldest sample only after the fill pass has written it.
    if (samples_filled >= WIN) window_sum -= 32'(ring_copy[next_slot]);
    ring_copy[next_slot] = smp;
    window_sum += 32'(smp);
    next_slot = (next_slot == POS_W'(WIN - 1)) ? '0 : next_slot + POS_W'(1);
    if (samples_filled < WIN) begin
      samples_filled++;
      return;
    end
    centi = window_sum * aref_copy / (100 * WIN);
    // Fahrenheit comes from the unclipped Celsius value.
    deci = centi * F_MUL / F_DIV + F_OFFSET;
    r.raw_average          = RAW_W'(window_sum / WIN);
    r.temp_centi_celsius   = (centi > 32'(CENTI_MAX)) ? CENTI_MAX : CENTI_W'(centi);
    r.temp_deci_fahrenheit = DECI_W'(deci);
    r.too_hot              = (window_sum == FULL_SCALE * WIN);
    expected_readings.push_back(r);
  endfunction

  // Compare one delivered reading with the oldest prediction.
  function automatic void check_reading();
    sts_result_t got;
    sts_result_t want;
    got.raw_average          = m_tdata[0 +: RAW_W];
    got.temp_centi_celsius   = m_tdata[RAW_W +: CENTI_W];
    got.temp_deci_fahrenheit = m_tdata[RAW_W + CENTI_W +: DECI_W];
    got.too_hot              = m_tuser;
    if (expected_readings.size() == 0) begin
      if (mismatch_count < MAX_REPORTS)
        $display("unexpected reading: raw=%0d centi=%0d deci=%0d hot=%0b",
                 got.raw_average, got.temp_centi_celsius,
                 got.temp_deci_fahrenheit, got.too_hot);
      mismatch_count++;
    end else begin
      want = expected_readings.pop_front();
      if (got !== want) begin
        if (mismatch_count < MAX_REPORTS) begin
          $write("reading %0d: expected raw=%0d centi=%0d deci=%0d hot=%0b, ",
                 results_seen, want.raw_average, want.temp_centi_celsius,
                 want.temp_deci_fahrenheit, want.too_hot);
          $display("got raw=%0d centi=%0d deci=%0d hot=%0b",
                   got.raw_average, got.temp_centi_celsius,
                   got.temp_deci_fahrenheit, got.too_hot);
        end
        mismatch_count++;
      end
    end
  endfunction

  function automatic void push_sample(input logic [SAMPLE_W-1:0] v);
    pending_samples.push_back(v);
    queued_count++;
  endfunction

  // Queue n random samples as runs: full-scale runs at least a window long
  // (so the too-hot flag fires), near full scale, low values, single set
  // bits, and plain uniform noise.
  task automatic queue_random_samples(input int n);
    int cnt;
    int kind;
    int run;
    int j;
    logic [SAMPLE_W-1:0] v;
    cnt = 0;
    while (cnt < n) begin
      kind = $urandom_range(0, 99);
      run  = (kind < 20) ? WIN + $urandom_range(0, 8) : $urandom_range(1, 20);
      for (j = 0; j < run && cnt < n; j++) begin
        if (kind < 20)      v = SAMPLE_W'(FULL_SCALE);
        else if (kind < 35) v = SAMPLE_W'(FULL_SCALE - $urandom_range(0, 8));
        else if (kind < 45) v = SAMPLE_W'($urandom_range(0, 15));
        else if (kind < 55) v = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
        else                v = SAMPLE_W'($urandom_range(0, FULL_SCALE));
        push_sample(v);
        cnt++;
      end
    end
  endtask

  // Hold until every queued sample is taken and every reading is back, then
  // let the pipe settle, since fill samples leave no reading to wait for.
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the reference register while the block is idle.
  task automatic write_aref(input logic [AREF_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    aref_copy   = 32'(v);
  endtask

  // Source side: predict on each accepted request, then offer the next
  // sample after its drawn gap. s_tvalid gets at most one assignment per edge.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      src_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_reading(s_tdata[SAMPLE_W-1:0]);
        accepted_count++;
        src_wait = draw_gap(src_left, src_calm);
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          s_tdata  <= IN_TDATA_W'(pending_samples.pop_front());
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each accepted reading, then drop ready for the drawn
  // gap or for as long as the long hold-off runs.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_reading();
        results_seen <= results_seen + 1;
        sink_wait = draw_gap(sink_left, sink_calm);
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long hold-off of the sink, counted here: the source keeps offering, so
  // the total queue fills and s_tready must fall.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!rst && holds_done < HOLD_TIMES &&
                 results_seen >= HOLD_EVERY * (holds_done + 1)) begin
      hold_left  <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset reference: fill the ring at full scale, then one more full-scale
    // sample (too hot) and a few extremes and bit patterns.
    for (k = 0; k < WIN; k++) push_sample(SAMPLE_W'(FULL_SCALE));
    push_sample(SAMPLE_W'(FULL_SCALE));
    push_sample(SAMPLE_W'(0));
    push_sample(SAMPLE_W'(1));
    push_sample(SAMPLE_W'('h155));
    push_sample(SAMPLE_W'('h2AA));
    push_sample(SAMPLE_W'(512));

    // Highest nominal reference: refill at full scale for the top reading.
    write_aref(AREF_W'(AREF_HIGH));
    for (k = 0; k < WIN; k++) push_sample(SAMPLE_W'(FULL_SCALE));

    // Reference past range: Celsius clips, Fahrenheit does not.
    write_aref(AREF_W'(AREF_FULL));
    push_sample(SAMPLE_W'(FULL_SCALE));
    push_sample(SAMPLE_W'(FULL_SCALE));
    push_sample(SAMPLE_W'(0));

    // Zero reference.
    write_aref(AREF_W'(0));
    push_sample(SAMPLE_W'(FULL_SCALE));
    push_sample(SAMPLE_W'(0));

    // Lowest nominal reference: flush the ring down to an all-zero window.
    write_aref(AREF_W'(AREF_LOW));
    for (k = 0; k < WIN; k++) push_sample(SAMPLE_W'(0));

    // Random phases, each under its own reference setting.
    while (random_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       aref_pick = AREF_W'($urandom_range(AREF_LOW, AREF_HIGH));
      else if (pick == 6) aref_pick = AREF_W'(AREF_LOW);
      else if (pick == 7) aref_pick = AREF_W'(AREF_HIGH);
      else if (pick == 8) aref_pick = AREF_W'($urandom_range(AREF_HIGH + 1, AREF_FULL));
      else                aref_pick = AREF_W'($urandom_range(0, AREF_LOW - 1));
      write_aref(aref_pick);
      phase_len = $urandom_range(100, 250);
      queue_random_samples(phase_len);
      random_count += phase_len;
    end

    wait_drained();
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
